>>> rtl/haptic_detent_pd_control_assert.svh
// Assertion macros for the haptic detent PD controller.
`ifndef HAPTIC_DETENT_PD_CONTROL_ASSERT_SVH
`define HAPTIC_DETENT_PD_CONTROL_ASSERT_SVH

`ifndef NO_ASSERTIONS

// A condition that must hold at every clock edge out of reset.
`define HDPC_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// A consequence that must hold in the cycle after its trigger.
`define HDPC_ASSERT_NEXT(lbl, trig, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cons)) \
    else $error(msg);

`else

`define HDPC_ASSERT_ALWAYS(lbl, cond, msg)
`define HDPC_ASSERT_NEXT(lbl, trig, cons, msg)

`endif

`endif

>>> rtl/hdpc_pkg.sv
// Shared types and constants for the haptic detent PD controller.
package hdpc_pkg;

  // Angle resolution: angles are fractions of a turn on this many bits.
  localparam int ANGLE_BITS = 16;

  // Fixed port widths.
  localparam int FIELD_W    = 16;
  localparam int GAIN_W     = 16;
  localparam int LIMIT_W    = 15;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Common width for carrying angles and 16-bit fields side by side.
  localparam int WIDE_W = (ANGLE_BITS > FIELD_W) ? ANGLE_BITS : FIELD_W;

  // Width of the doubled difference compared against the detent size.
  localparam int CMP_W = ((ANGLE_BITS + 1 > GAIN_W + 1) ? ANGLE_BITS + 1 : GAIN_W + 1) + 1;

  // Product and sum widths of the PD term.
  localparam int KP_PROD_W = ANGLE_BITS + GAIN_W + 1;
  localparam int KD_PROD_W = GAIN_W + FIELD_W + 1;
  localparam int SUM_W     = ((KP_PROD_W > KD_PROD_W) ? KP_PROD_W : KD_PROD_W) + 1;
  localparam int FRAC_BITS = 8;
  localparam int TQ_W      = SUM_W - FRAC_BITS;

  // Register indexes of the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KP_GAIN      = 3'd0,
    REG_KD_GAIN      = 3'd1,
    REG_DETENT_SIZE  = 3'd2,
    REG_TORQUE_LIMIT = 3'd3
  } cfg_reg_e;

  // Configuration register file.
  typedef struct packed {
    logic [GAIN_W-1:0]  kp;
    logic [GAIN_W-1:0]  kd;
    logic [GAIN_W-1:0]  detent;
    logic [LIMIT_W-1:0] limit;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    kp:     16'd1152,
    kd:     16'd26,
    detent: 16'd4096,
    limit:  15'd24576
  };

  // Word passed from the detent stage to the PD stage.
  typedef struct packed {
    logic signed [ANGLE_BITS-1:0] err;
    logic signed [FIELD_W-1:0]    vel;
    logic [FIELD_W-1:0]           target;
  } err_item_t;

endpackage

>>> rtl/hdpc_cfg.sv
// Configuration registers of the haptic detent PD controller.
module hdpc_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [hdpc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [hdpc_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output hdpc_pkg::cfg_t                 cfg_o
);
  import hdpc_pkg::*;

  cfg_t cfg_q, cfg_d;

  // Decode the register index; unknown indexes leave everything alone.
  always_comb begin
    cfg_d = cfg_q;
    unique case (cfg_idx_i)
      REG_KP_GAIN:      cfg_d.kp     = cfg_data_i;
      REG_KD_GAIN:      cfg_d.kd     = cfg_data_i;
      REG_DETENT_SIZE:  cfg_d.detent = cfg_data_i;
      REG_TORQUE_LIMIT: cfg_d.limit  = cfg_data_i[LIMIT_W-1:0];
      default:          cfg_d        = cfg_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (cfg_we_i) begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> rtl/hdpc_target.sv
// Input register and detent target tracking stage.
module hdpc_target (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [hdpc_pkg::FIELD_W-1:0]        shaft_angle_i,
  input  logic signed [hdpc_pkg::FIELD_W-1:0] shaft_velocity_i,
  input  logic [hdpc_pkg::GAIN_W-1:0]         detent_size_i,
  output logic                                err_valid_o,
  input  logic                                err_ready_i,
  output hdpc_pkg::err_item_t                 err_item_o
);
  import hdpc_pkg::*;

  logic                         s1_valid_q;
  logic [ANGLE_BITS-1:0]        s1_angle_q;
  logic signed [FIELD_W-1:0]    s1_vel_q;
  logic [ANGLE_BITS-1:0]        target_q, target_d;
  logic                         s2_valid_q;
  logic signed [ANGLE_BITS-1:0] s2_err_q, err_d;
  logic signed [FIELD_W-1:0]    s2_vel_q;

  logic                         s1_ready, s2_ready, advance;
  logic [WIDE_W-1:0]            angle_wide, detent_wide, target_wide;
  logic [ANGLE_BITS-1:0]        s1_angle_d, step, diff;
  logic signed [CMP_W-1:0]      diff2, det_cmp;

  // Each stage takes a new word when it is empty or its word moves on.
  assign s2_ready   = !s2_valid_q || err_ready_i;
  assign s1_ready   = !s1_valid_q || s2_ready;
  assign advance    = s1_valid_q && s2_ready;
  assign in_stall_o = !s1_ready;

  // Bring the 16-bit fields to angle width.
  assign angle_wide  = WIDE_W'(shaft_angle_i);
  assign s1_angle_d  = angle_wide[ANGLE_BITS-1:0];
  assign detent_wide = WIDE_W'(detent_size_i);
  assign step        = detent_wide[ANGLE_BITS-1:0];

  // Step the target one detent when the angle is beyond half a detent away.
  assign diff    = s1_angle_q - target_q;
  assign diff2   = CMP_W'($signed(diff)) <<< 1;
  assign det_cmp = $signed(CMP_W'(detent_size_i));

  always_comb begin
    priority if (diff2 > det_cmp) begin
      target_d = target_q + step;
    end else if (diff2 < -det_cmp) begin
      target_d = target_q - step;
    end else begin
      target_d = target_q;
    end
  end

  assign err_d = $signed(target_d - s1_angle_q);

  // Valid flags and the target state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      target_q   <= '0;
    end else begin
      if (s1_ready) begin
        s1_valid_q <= in_valid_i;
      end
      if (s2_ready) begin
        s2_valid_q <= s1_valid_q;
      end
      if (advance) begin
        target_q <= target_d;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (s1_ready && in_valid_i) begin
      s1_angle_q <= s1_angle_d;
      s1_vel_q   <= shaft_velocity_i;
    end
    if (advance) begin
      s2_err_q <= err_d;
      s2_vel_q <= s1_vel_q;
    end
  end

  // The target state is the target of the newest word in the second stage.
  assign target_wide       = WIDE_W'(target_q);
  assign err_valid_o       = s2_valid_q;
  assign err_item_o.err    = s2_err_q;
  assign err_item_o.vel    = s2_vel_q;
  assign err_item_o.target = target_wide[FIELD_W-1:0];

endmodule

>>> rtl/hdpc_pd.sv
// Gain multipliers, rounding, saturation and the result register.
module hdpc_pd (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                err_valid_i,
  output logic                                err_ready_o,
  input  hdpc_pkg::err_item_t                 err_item_i,
  input  logic [hdpc_pkg::GAIN_W-1:0]         kp_gain_i,
  input  logic [hdpc_pkg::GAIN_W-1:0]         kd_gain_i,
  input  logic [hdpc_pkg::LIMIT_W-1:0]        torque_limit_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [hdpc_pkg::FIELD_W-1:0] torque_command_o,
  output logic [hdpc_pkg::FIELD_W-1:0]        target_position_o
);
  import hdpc_pkg::*;

  logic                        s3_valid_q;
  logic signed [KP_PROD_W-1:0] kp_prod_q, kp_prod_d;
  logic signed [KD_PROD_W-1:0] kd_prod_q, kd_prod_d;
  logic [FIELD_W-1:0]          s3_target_q;
  logic                        out_valid_q;
  logic signed [FIELD_W-1:0]   torque_q, torque_d;
  logic [FIELD_W-1:0]          out_target_q;

  logic                        out_ready, s3_ready;
  logic signed [GAIN_W:0]      kp_s, kd_s;
  logic signed [SUM_W-1:0]     sum;
  logic signed [TQ_W-1:0]      tq, lim, sat;

  assign out_ready   = !out_valid_q || !out_stall_i;
  assign s3_ready    = !s3_valid_q || out_ready;
  assign err_ready_o = s3_ready;

  // Gains are unsigned; give them a zero sign bit.
  assign kp_s      = $signed({1'b0, kp_gain_i});
  assign kd_s      = $signed({1'b0, kd_gain_i});
  assign kp_prod_d = KP_PROD_W'(kp_s) * KP_PROD_W'(err_item_i.err);
  assign kd_prod_d = KD_PROD_W'(kd_s) * KD_PROD_W'(err_item_i.vel);

  // Round half up, then an arithmetic shift gives the floor of the Q8.8 result.
  assign sum = SUM_W'(kp_prod_q) - SUM_W'(kd_prod_q) + (SUM_W'(1) <<< (FRAC_BITS - 1));
  assign tq  = $signed(sum[SUM_W-1:FRAC_BITS]);
  assign lim = $signed(TQ_W'(torque_limit_i));

  // Clamp to the symmetric torque limit.
  always_comb begin
    priority if (tq > lim) begin
      sat = lim;
    end else if (tq < -lim) begin
      sat = -lim;
    end else begin
      sat = tq;
    end
  end

  assign torque_d = $signed(sat[FIELD_W-1:0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s3_ready) begin
        s3_valid_q <= err_valid_i;
      end
      if (out_ready) begin
        out_valid_q <= s3_valid_q;
      end
    end
  end

  // Product and result payload registers.
  always_ff @(posedge clk_i) begin
    if (s3_ready && err_valid_i) begin
      kp_prod_q   <= kp_prod_d;
      kd_prod_q   <= kd_prod_d;
      s3_target_q <= err_item_i.target;
    end
    if (out_ready && s3_valid_q) begin
      torque_q     <= torque_d;
      out_target_q <= s3_target_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign torque_command_o  = torque_q;
  assign target_position_o = out_target_q;

endmodule

>>> rtl/haptic_detent_pd_control.sv
// Haptic detent PD controller: four-stage pipeline with configuration registers.
//
// Takes one word per clock while out_stall_i is low: shaft angle and velocity
// in, torque command and detent target out. The first stage registers the
// input; the second moves the detent target by at most one detent and forms
// the wrapped position error, and the target feedback closes inside that
// stage, which is what sets the one-word-per-clock rate; the third holds the
// two gain products; the fourth rounds, clamps to the torque limit and holds
// the result until it is taken. Each stage refills as soon as its word moves
// on, so a bubble anywhere lets a new word in while a result waits.
// Configuration writes take effect on the next edge and belong in idle
// periods. No clearing pass is needed after reset.
module haptic_detent_pd_control (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [hdpc_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [hdpc_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [hdpc_pkg::FIELD_W-1:0]        shaft_angle_i,
  input  logic signed [hdpc_pkg::FIELD_W-1:0] shaft_velocity_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [hdpc_pkg::FIELD_W-1:0] torque_command_o,
  output logic [hdpc_pkg::FIELD_W-1:0]        target_position_o
);
  import hdpc_pkg::*;

  cfg_t      cfg;
  logic      err_valid, err_ready;
  err_item_t err_item;

  // Configuration registers.
  hdpc_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  // Input register and detent tracking.
  hdpc_target u_target (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .shaft_angle_i    (shaft_angle_i),
    .shaft_velocity_i (shaft_velocity_i),
    .detent_size_i    (cfg.detent),
    .err_valid_o      (err_valid),
    .err_ready_i      (err_ready),
    .err_item_o       (err_item)
  );

  // PD torque and result register.
  hdpc_pd u_pd (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .err_valid_i       (err_valid),
    .err_ready_o       (err_ready),
    .err_item_i        (err_item),
    .kp_gain_i         (cfg.kp),
    .kd_gain_i         (cfg.kd),
    .torque_limit_i    (cfg.limit),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .torque_command_o  (torque_command_o),
    .target_position_o (target_position_o)
  );

  // Checks on the pipeline and the clamp.
  `include "haptic_detent_pd_control_assert.svh"

  // The input side only stalls when every stage is full behind a stalled result.
  `HDPC_ASSERT_ALWAYS(a_stall_only_when_full, !in_stall_o || (out_valid_o && out_stall_i), "input stalled while the pipeline has room")

  // A valid torque never exceeds the configured limit.
  `HDPC_ASSERT_ALWAYS(a_torque_in_limit, !out_valid_o || (($signed(torque_command_o) <= $signed({1'b0, cfg.limit})) && ($signed(torque_command_o) >= -$signed({1'b0, cfg.limit}))), "torque command beyond the limit")

  // A detent size write lands in the register used by the tracking stage.
  `HDPC_ASSERT_NEXT(a_detent_write, cfg_we_i && (cfg_idx_i == REG_DETENT_SIZE), cfg.detent == $past(cfg_data_i), "detent size write lost")

endmodule

>>> bench/hdpc_checker.sv
// Result checker for the haptic detent PD controller: predicts each word and compares.
module hdpc_checker (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [hdpc_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [hdpc_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                                in_valid_i,
  input  logic                                in_stall_i,
  input  logic [hdpc_pkg::FIELD_W-1:0]        shaft_angle_i,
  input  logic signed [hdpc_pkg::FIELD_W-1:0] shaft_velocity_i,
  input  logic                                out_valid_i,
  input  logic                                out_stall_i,
  input  logic signed [hdpc_pkg::FIELD_W-1:0] torque_command_i,
  input  logic [hdpc_pkg::FIELD_W-1:0]        target_position_i,
  output int                                  fail_count_o,
  output int                                  pending_o
);
  import hdpc_pkg::*;

  localparam int REPORT_LIMIT = 10;

  // One expected result word.
  typedef struct packed {
    logic signed [FIELD_W-1:0] torque;
    logic [FIELD_W-1:0]        target;
  } tick_word_t;

  cfg_t                  cfg_q;
  logic [ANGLE_BITS-1:0] detent_target;
  tick_word_t            tick_words_q[$];
  int                    mismatch_cnt = 0;
  int                    pending_cnt = 0;

  assign fail_count_o = mismatch_cnt;
  assign pending_o    = pending_cnt;

  // Works out the detent step and the saturated PD torque for one tick.
  function automatic tick_word_t predict_tick(
    input  logic [FIELD_W-1:0]        angle_raw,
    input  logic signed [FIELD_W-1:0] vel_raw,
    input  cfg_t                      cfg,
    input  logic [ANGLE_BITS-1:0]     tgt_in,
    output logic [ANGLE_BITS-1:0]     tgt_out
  );
    logic [ANGLE_BITS-1:0]        angle;
    logic signed [ANGLE_BITS-1:0] diff;
    logic signed [ANGLE_BITS-1:0] err;
    longint                       det, kp, kd, lim, vel, sum, torque;
    tick_word_t                   word;
    angle   = ANGLE_BITS'(angle_raw);
    det     = cfg.detent;
    kp      = cfg.kp;
    kd      = cfg.kd;
    lim     = cfg.limit;
    vel     = vel_raw;
    tgt_out = tgt_in;

    // The wrapped difference reads as two's complement; a step needs more than half a detent.
    diff = angle - tgt_in;
    if (2 * longint'(diff) > det) begin
      tgt_out = tgt_in + ANGLE_BITS'(cfg.detent);
    end else if (2 * longint'(diff) < -det) begin
      tgt_out = tgt_in - ANGLE_BITS'(cfg.detent);
    end

    // Q8.8 gains: add half an LSB and floor, then clamp to the limit.
    err    = tgt_out - angle;
    sum    = kp * longint'(err) - kd * vel;
    torque = (sum + 128) >>> 8;
    if (torque > lim) begin
      torque = lim;
    end else if (torque < -lim) begin
      torque = -lim;
    end

    word.torque = FIELD_W'(torque);
    word.target = FIELD_W'(tgt_out);
    return word;
  endfunction

  // Counts a failure and reports the first few.
  task automatic note_failure(input string what);
    mismatch_cnt++;
    if (mismatch_cnt <= REPORT_LIMIT) begin
      $display("[%0t] mismatch: %s", $realtime, what);
    end
  endtask

  // Compare result words, predict accepted input words and follow register writes.
  always @(posedge clk_i or negedge rst_ni) begin
    tick_word_t            exp_word;
    logic [ANGLE_BITS-1:0] next_target;
    if (!rst_ni) begin
      cfg_q         = CFG_RESET;
      detent_target = '0;
      tick_words_q.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (tick_words_q.size() == 0) begin
          note_failure($sformatf("result word with none expected (torque %0d target %0d)",
                                 torque_command_i, target_position_i));
        end else begin
          exp_word = tick_words_q.pop_front();
          if (torque_command_i !== exp_word.torque) begin
            note_failure($sformatf("torque_command expected %0d got %0d",
                                   exp_word.torque, torque_command_i));
          end
          if (target_position_i !== exp_word.target) begin
            note_failure($sformatf("target_position expected %0d got %0d",
                                   exp_word.target, target_position_i));
          end
        end
      end

      if (in_valid_i && !in_stall_i) begin
        exp_word = predict_tick(shaft_angle_i, shaft_velocity_i, cfg_q, detent_target,
                                next_target);
        detent_target = next_target;
        tick_words_q.push_back(exp_word);
      end

      // Writes to indexes outside the register list change nothing.
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_KP_GAIN:      cfg_q.kp     = cfg_data_i[GAIN_W-1:0];
          REG_KD_GAIN:      cfg_q.kd     = cfg_data_i[GAIN_W-1:0];
          REG_DETENT_SIZE:  cfg_q.detent = cfg_data_i[GAIN_W-1:0];
          REG_TORQUE_LIMIT: cfg_q.limit  = cfg_data_i[LIMIT_W-1:0];
          default: ;
        endcase
      end
    end
    pending_cnt = tick_words_q.size();
  end

endmodule

>>> bench/testbench.sv
// Top-level testbench for the haptic detent PD controller: stimulus, stalls and verdict.
module testbench;
  import hdpc_pkg::*;

  localparam int HALF_PERIOD    = 5;
  localparam int RESET_CYCLES   = 11;
  localparam int TIMEOUT_CYCLES = 400000;
  localparam int HOLD_CYCLES    = 300;
  localparam int SETTLE_CYCLES  = 4;
  localparam int DRAIN_CYCLES   = 16;
  localparam int PHASE_ITEMS    = 105;
  localparam int HOLD_ITEMS     = 40;
  localparam int QUIET_ITEMS    = 60;
  localparam int NUM_CFG_SETS   = 10;
  localparam logic [CFG_IDX_W-1:0] FIRST_SPARE_IDX = CFG_IDX_W'(4);

  // How the result side behaves.
  typedef enum logic [1:0] {
    RX_RANDOM,
    RX_HOLD,
    RX_QUIET
  } rx_mode_e;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]        cfg_idx = '0;
  logic [CFG_DATA_W-1:0]       cfg_data = '0;
  logic                        in_valid = 1'b0;
  logic                        in_stall;
  logic [FIELD_W-1:0]          shaft_angle = '0;
  logic signed [FIELD_W-1:0]   shaft_velocity = '0;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  logic signed [FIELD_W-1:0]   torque_command;
  logic [FIELD_W-1:0]          target_position;
  int                          fail_count;
  int                          pending;

  rx_mode_e                    rx_mode = RX_RANDOM;
  bit                          hold_done = 1'b0;
  logic [FIELD_W-1:0]          walk_angle = '0;
  int                          cur_detent = 4096;

  haptic_detent_pd_control u_dut (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .cfg_we_i          (cfg_we),
    .cfg_idx_i         (cfg_idx),
    .cfg_data_i        (cfg_data),
    .in_valid_i        (in_valid),
    .in_stall_o        (in_stall),
    .shaft_angle_i     (shaft_angle),
    .shaft_velocity_i  (shaft_velocity),
    .out_valid_o       (out_valid),
    .out_stall_i       (out_stall),
    .torque_command_o  (torque_command),
    .target_position_o (target_position)
  );

  hdpc_checker u_checker (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .cfg_we_i          (cfg_we),
    .cfg_idx_i         (cfg_idx),
    .cfg_data_i        (cfg_data),
    .in_valid_i        (in_valid),
    .in_stall_i        (in_stall),
    .shaft_angle_i     (shaft_angle),
    .shaft_velocity_i  (shaft_velocity),
    .out_valid_i       (out_valid),
    .out_stall_i       (out_stall),
    .torque_command_i  (torque_command),
    .target_position_i (target_position),
    .fail_count_o      (fail_count),
    .pending_o         (pending)
  );

  // Clock.
  always begin
    #HALF_PERIOD clk = 1'b1;
    #HALF_PERIOD clk = 1'b0;
  end

  // Offers one word and returns at the falling edge after it is taken.
  task automatic send_word(input logic [FIELD_W-1:0] angle,
                           input logic signed [FIELD_W-1:0] vel);
    in_valid       <= 1'b1;
    shaft_angle    <= angle;
    shaft_velocity <= vel;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // Leaves the input side idle for a number of cycles.
  task automatic idle_in(input int cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  // Holds off new words until every expected result has come out.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Writes all four registers, preceded by a write to an unused index.
  task automatic apply_config(input logic [GAIN_W-1:0] kp, input logic [GAIN_W-1:0] kd,
                              input logic [GAIN_W-1:0] det,
                              input logic [LIMIT_W-1:0] lim);
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_IDX_W'($urandom_range(int'(FIRST_SPARE_IDX), (1 << CFG_IDX_W) - 1));
    cfg_data <= CFG_DATA_W'($urandom);
    @(negedge clk);
    cfg_idx  <= REG_KP_GAIN;
    cfg_data <= kp;
    @(negedge clk);
    cfg_idx  <= REG_KD_GAIN;
    cfg_data <= kd;
    @(negedge clk);
    cfg_idx  <= REG_DETENT_SIZE;
    cfg_data <= det;
    @(negedge clk);
    // The top bit of the limit write is not part of the register.
    cfg_idx  <= REG_TORQUE_LIMIT;
    cfg_data <= {1'($urandom), lim};
    @(negedge clk);
    cfg_we   <= 1'b0;
    cur_detent = det;
  endtask

  // Sends one random word: mostly a shaft that wanders across detents, some jumps and extremes.
  task automatic send_random(input bit gaps_on);
    int                        span;
    int                        pick;
    logic [FIELD_W-1:0]        angle;
    logic signed [FIELD_W-1:0] vel;
    span = (cur_detent == 0) ? 64 : cur_detent;
    if ($urandom_range(0, 1) == 0) span = span / 8 + 1;
    pick = $urandom_range(0, 99);
    if (pick < 65) begin
      angle = walk_angle + FIELD_W'($urandom_range(0, 2 * span) - span);
    end else if (pick < 85) begin
      angle = FIELD_W'($urandom);
    end else begin
      case ($urandom_range(0, 3))
        0:       angle = '0;
        1:       angle = '1;
        2:       angle = 16'h8000;
        default: angle = 16'h7FFF;
      endcase
    end
    walk_angle = angle;

    pick = $urandom_range(0, 9);
    if (pick < 5) begin
      vel = FIELD_W'($urandom);
    end else if (pick < 8) begin
      vel = FIELD_W'($urandom_range(0, 400) - 200);
    end else begin
      case ($urandom_range(0, 3))
        0:       vel = 16'sh8000;
        1:       vel = 16'sh7FFF;
        2:       vel = '0;
        default: vel = '1;
      endcase
    end

    send_word(angle, vel);
    if (gaps_on && $urandom_range(0, 7) == 0) idle_in($urandom_range(1, 16));
  endtask

  // Result side: random stall bursts, one long hold-off, and no stalls at the end.
  initial begin
    @(negedge clk);
    forever begin
      if (rx_mode == RX_QUIET) begin
        out_stall <= 1'b0;
        @(negedge clk);
      end else if (rx_mode == RX_HOLD && !hold_done) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_done = 1'b1;
      end else begin
        out_stall <= ($urandom_range(0, 2) == 0);
        repeat ($urandom_range(1, 16)) @(negedge clk);
      end
    end
  end

  // Stimulus and verdict.
  initial begin
    logic [GAIN_W-1:0]  kp, kd, det;
    logic [LIMIT_W-1:0] lim;
    bit                 gaps;

    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset gains, sixteen detents per turn, target starts at zero.
    send_word(16'd0, 16'sd0);
    send_word(16'd2048, 16'sd0);          // exactly half a detent up: no step
    send_word(16'd2049, 16'sh7FFF);       // just past half: step up to 4096
    send_word(16'd36864, 16'sh8000);      // half a turn away reads negative: step back
    send_word(16'd65535, -16'sd1);
    send_word(16'd63488, 16'sd1);         // exactly half a detent down: no step
    send_word(16'd63487, 16'sd0);         // just past half down: step to 61440

    // Odd detent size with the largest gains and limit.
    wait_idle();
    apply_config(16'hFFFF, 16'hFFFF, 16'd3, 15'h7FFF);
    send_word(16'd61441, 16'sd0);
    send_word(16'd61442, 16'sh7FFF);
    send_word(16'd61441, 16'sh8000);

    // Zero detent size and zero limit: no step and no torque.
    wait_idle();
    apply_config(16'd0, 16'd0, 16'd0, 15'd0);
    send_word(16'd30000, 16'sd12345);
    send_word(16'd28672, 16'sh8000);

    // A detent almost a full turn wraps when it steps.
    wait_idle();
    apply_config(16'd1152, 16'd26, 16'hFFFF, 15'd24576);
    send_word(16'd28672, 16'sd0);
    send_word(16'd28672, 16'sd300);
    send_word(16'd0, 16'sd100);
    send_word(16'd65535, -16'sd100);

    // Random words across several register settings.
    for (int s = 0; s < NUM_CFG_SETS; s++) begin
      case (s)
        0:       begin kp = 16'd1152;  kd = 16'd26;    det = 16'd4096;  lim = 15'd24576; end
        1:       begin kp = 16'hFFFF;  kd = 16'hFFFF;  det = 16'd32768; lim = 15'h7FFF;  end
        2:       begin kp = 16'd0;     kd = 16'd0;     det = 16'd2;     lim = 15'd0;     end
        3:       begin kp = 16'd1152;  kd = 16'd26;    det = 16'hFFFF;  lim = 15'h7FFF;  end
        4:       begin kp = 16'd300;   kd = 16'd5;     det = 16'd1;     lim = 15'd1000;  end
        5:       begin kp = 16'd0;     kd = 16'hFFFF;  det = 16'd0;     lim = 15'h7FFF;  end
        6:       begin kp = 16'hFFFF;  kd = 16'd0;     det = 16'd7;     lim = 15'd100;   end
        default: begin
          kp  = GAIN_W'($urandom_range(0, 4096));
          kd  = GAIN_W'($urandom_range(0, 512));
          det = GAIN_W'($urandom_range(2, 32768));
          lim = LIMIT_W'($urandom);
        end
      endcase
      wait_idle();
      apply_config(kp, kd, det, lim);
      gaps = 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n % 35 == 0) gaps = ($urandom_range(0, 3) != 0);
        send_random(gaps);
      end

      // Once, the result side holds off while words keep coming, so the pipe backs up.
      if (s == 2) begin
        rx_mode = RX_HOLD;
        repeat (HOLD_ITEMS) send_random(1'b0);
        while (!hold_done) @(negedge clk);
        rx_mode = RX_RANDOM;
      end
    end

    // Last part: back-to-back words with no stalls on either side.
    wait_idle();
    rx_mode = RX_QUIET;
    apply_config(16'd1152, 16'd26, 16'd4096, 15'd24576);
    repeat (QUIET_ITEMS) send_random(1'b0);
    in_valid <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #(TIMEOUT_CYCLES * 2 * HALF_PERIOD);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
